/* sv/gradient_center_voting_assert.svh */
// assertion macros used by the checker of the voting block
`ifndef GRADIENT_CENTER_VOTING_ASSERT_SVH
`define GRADIENT_CENTER_VOTING_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define GCV_ASSERT_HOLD(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gradient_center_voting: same-cycle check failed");

// next-cycle implication, clocked on clock, off during reset
`define GCV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gradient_center_voting: next-cycle check failed");

`endif

/* sv/gcv_pkg.sv */
package gcv_pkg;

   // field widths
   localparam int POS_W     = 6;
   localparam int GRAD_W    = 16;
   localparam int WEIGHT_W  = 8;
   localparam int SCORE_W   = 36;
   localparam int SHIFT_W   = 4;
   localparam int OP_W      = 2;
   localparam int FRAC_BITS = 15;
   // vote quotient never exceeds 2^16
   localparam int QUOT_W    = 17;
   localparam int WVOTE_W   = QUOT_W + WEIGHT_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;
   // cycles to let the vote pipeline empty after the last centre
   localparam int DRAIN_CYC = 24;
   localparam int DRAIN_W   = 5;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // configuration register indexes
   localparam logic CSR_WEIGHT_EN    = 1'b0;
   localparam logic CSR_WEIGHT_SHIFT = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_VOTE   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VOTE,
      ST_DRAIN,
      ST_SCAN,
      ST_SCAN_END,
      ST_REPORT
   } state_type;

endpackage

/* sv/gcv_ram.sv */
module gcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gradient_center_voting.sv */
// Eye-centre vote map. A load transaction (tuser 0) writes one weight pixel and clears the
// score at that position. A gradient transaction (tuser 1) sweeps every centre of the
// IMG_WIDTH x IMG_HEIGHT map one per cycle through a 22-stage pipeline (dot product, square,
// 17-step divider, weighting, saturating add); the single read port of the score RAM sets
// that pace. A finish transaction (tuser 2) scans the score RAM one entry per cycle and
// returns the first row-major maximum. After reset a clearing pass zeroes the score RAM;
// req_tready stays low meanwhile, configuration writes are taken always.
module gradient_center_voting
   import gcv_pkg::*;
#(
   parameter int IMG_WIDTH  = 64,
   parameter int IMG_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, grad_x, grad_y, pixel_weight, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // center_x, center_y, peak_score
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [SHIFT_W-1:0]    csr_data
);

   localparam int N    = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW   = $clog2(N);
   localparam int XW   = $clog2(IMG_WIDTH);
   localparam int YW   = $clog2(IMG_HEIGHT);
   localparam int CW0  = (XW > YW) ? XW : YW;
   localparam int CW   = (CW0 > POS_W) ? CW0 : POS_W;
   localparam int DW   = CW + 2;
   localparam int PW   = DW + GRAD_W;
   localparam int NW   = PW + 1;
   localparam int UW   = NW - 1;
   localparam int SQW  = 2 * UW;
   localparam int DQW  = 2 * DW;
   localparam int DVW  = DQW + FRAC_BITS;
   localparam int LW   = (SQW > DVW + QUOT_W) ? SQW : DVW + QUOT_W;

   // input fields
   logic [POS_W-1:0]           in_px, in_py;
   logic signed [GRAD_W-1:0]   in_gx, in_gy;
   logic [WEIGHT_W-1:0]        in_w;
   logic                       req_acc;
   logic                       load_in_map;
   logic [AW-1:0]              load_addr;

   assign in_px   = req_tdata[5:0];
   assign in_py   = req_tdata[11:6];
   assign in_gx   = $signed(req_tdata[27:12]);
   assign in_gy   = $signed(req_tdata[43:28]);
   assign in_w    = req_tdata[51:44];
   assign req_acc = req_tvalid && req_tready;

   assign load_in_map = (int'(in_px) < IMG_WIDTH) && (int'(in_py) < IMG_HEIGHT);
   assign load_addr   = AW'(int'(in_py) * IMG_WIDTH + int'(in_px));

   // configuration registers
   logic               wen_ff;
   logic [SHIFT_W-1:0] wsh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wen_ff <= 1'b1;
         wsh_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WEIGHT_EN:    wen_ff <= csr_data[0];
            CSR_WEIGHT_SHIFT: wsh_ff <= csr_data;
         endcase
      end
   end

   // control
   state_type          state_ff, state_in;
   logic [AW-1:0]      addr_ff;
   logic [XW-1:0]      cx_ff;
   logic [YW-1:0]      cy_ff;
   logic [DRAIN_W-1:0] drain_ff;
   logic               cnt_step, cnt_last, drain_step, issue, scan_issue, rsp_load;
   logic               vote_start;

   assign cnt_last = (addr_ff == AW'(N - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cnt_step   = 1'b0;
      drain_step = 1'b0;
      issue      = 1'b0;
      scan_issue = 1'b0;
      rsp_load   = 1'b0;
      vote_start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_step = 1'b1;
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_VOTE) begin
                  vote_start = 1'b1;
                  state_in   = ST_VOTE;
               end else if (req_tuser == OP_FINISH) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_VOTE: begin
            issue    = 1'b1;
            cnt_step = 1'b1;
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_step = 1'b1;
            if (drain_ff == DRAIN_W'(DRAIN_CYC - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            scan_issue = 1'b1;
            cnt_step   = 1'b1;
            if (cnt_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_tvalid || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // map sweep counters, back to zero after the last entry
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         drain_ff <= '0;
      end else begin
         if (cnt_step) begin
            if (cnt_last) begin
               addr_ff <= '0;
               cx_ff   <= '0;
               cy_ff   <= '0;
            end else begin
               addr_ff <= addr_ff + 1'b1;
               if (cx_ff == XW'(IMG_WIDTH - 1)) begin
                  cx_ff <= '0;
                  cy_ff <= cy_ff + 1'b1;
               end else begin
                  cx_ff <= cx_ff + 1'b1;
               end
            end
         end
         drain_ff <= drain_step ? drain_ff + 1'b1 : '0;
      end
   end

   // gradient held for the sweep
   logic [POS_W-1:0]         ox_ff, oy_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;

   always_ff @(posedge clock) begin
      if (vote_start) begin
         ox_ff <= in_px;
         oy_ff <= in_py;
         gx_ff <= in_gx;
         gy_ff <= in_gy;
      end
   end

   // stage 1: offsets and products
   logic signed [DW-1:0]  dx, dy;
   logic signed [PW-1:0]  p1_ff, p2_ff;
   logic [DQW-1:0]        sxx_ff, syy_ff;
   logic                  org1_ff, v1_ff;
   logic [AW-1:0]         a1_ff;

   assign dx = $signed(DW'(ox_ff)) - $signed(DW'(cx_ff));
   assign dy = $signed(DW'(oy_ff)) - $signed(DW'(cy_ff));

   always_ff @(posedge clock) begin
      p1_ff   <= PW'(dx * gx_ff);
      p2_ff   <= PW'(dy * gy_ff);
      sxx_ff  <= $unsigned(DQW'(dx * dx));
      syy_ff  <= $unsigned(DQW'(dy * dy));
      org1_ff <= (dx == '0) && (dy == '0);
      a1_ff   <= addr_ff;
   end

   // stage 2: dot product and squared distance
   logic signed [NW-1:0] num;
   logic [UW-1:0]        un2_ff;
   logic [DQW-1:0]       d2_ff;
   logic                 v2_ff;
   logic [AW-1:0]        a2_ff;

   assign num = NW'(p1_ff) + NW'(p2_ff);

   always_ff @(posedge clock) begin
      un2_ff <= num[UW-1:0];
      d2_ff  <= DQW'(sxx_ff + syy_ff);
      a2_ff  <= a1_ff;
   end

   // stage 3: square of the dot product, scaled divisor
   logic [LW-1:0]  drem_ff [QUOT_W+1];
   logic [DVW-1:0] ddiv_ff [QUOT_W+1];
   logic [QUOT_W-1:0] dq_ff [QUOT_W+1];
   logic [AW-1:0]  da_ff   [QUOT_W+1];
   logic           dv_ff   [QUOT_W+1];

   always_ff @(posedge clock) begin
      drem_ff[0] <= LW'(un2_ff * un2_ff);
      ddiv_ff[0] <= DVW'(d2_ff) << FRAC_BITS;
      dq_ff[0]   <= '0;
      da_ff[0]   <= a2_ff;
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else begin
         v1_ff    <= issue;
         v2_ff    <= v1_ff && !org1_ff && !num[NW-1] && (num != '0);
         dv_ff[0] <= v2_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      logic [LW-1:0] shifted;
      logic          ge;

      assign shifted = LW'(ddiv_ff[j]) << (QUOT_W - 1 - j);
      assign ge      = drem_ff[j] >= shifted;

      always_ff @(posedge clock) begin
         drem_ff[j+1] <= ge ? drem_ff[j] - shifted : drem_ff[j];
         ddiv_ff[j+1] <= ddiv_ff[j];
         dq_ff[j+1]   <= {dq_ff[j][QUOT_W-2:0], ge};
         da_ff[j+1]   <= da_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
   end

   // stage 4: memories answer, weighting
   logic [QUOT_W-1:0]   q4_ff;
   logic [AW-1:0]       a4_ff;
   logic                v4_ff;
   logic [WEIGHT_W-1:0] w_rd;
   logic [SCORE_W-1:0]  sum_rd;
   logic [WVOTE_W-1:0]  wprod, wvote;

   assign wprod = WVOTE_W'(q4_ff) * WVOTE_W'(w_rd);
   assign wvote = wen_ff ? (wprod >> wsh_ff) : WVOTE_W'(q4_ff);

   always_ff @(posedge clock) begin
      q4_ff <= dq_ff[QUOT_W];
      a4_ff <= da_ff[QUOT_W];
   end

   // stage 5: saturating accumulate
   logic [WVOTE_W-1:0] wv5_ff;
   logic [SCORE_W-1:0] sum5_ff;
   logic [AW-1:0]      a5_ff;
   logic               v5_ff;
   logic [SCORE_W:0]   acc;
   logic [SCORE_W-1:0] acc_sat;

   assign acc     = (SCORE_W+1)'(sum5_ff) + (SCORE_W+1)'(wv5_ff);
   assign acc_sat = acc[SCORE_W] ? SCORE_MAX : acc[SCORE_W-1:0];

   always_ff @(posedge clock) begin
      wv5_ff  <= wvote;
      sum5_ff <= sum_rd;
      a5_ff   <= a4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= dv_ff[QUOT_W];
         v5_ff <= v4_ff;
      end
   end

   // memory ports
   logic               sw_en, sr_en, ww_en;
   logic [AW-1:0]      sw_addr, sr_addr;
   logic [SCORE_W-1:0] sw_data;
   logic               load_go;

   assign load_go = req_acc && (req_tuser == OP_LOAD) && load_in_map;
   assign ww_en   = load_go;
   assign sr_en   = scan_issue || dv_ff[QUOT_W];
   assign sr_addr = scan_issue ? addr_ff : da_ff[QUOT_W];

   always_comb begin
      priority if (state_ff == ST_CLEAR) begin
         sw_en   = 1'b1;
         sw_addr = addr_ff;
         sw_data = '0;
      end else if (load_go) begin
         sw_en   = 1'b1;
         sw_addr = load_addr;
         sw_data = '0;
      end else begin
         sw_en   = v5_ff;
         sw_addr = a5_ff;
         sw_data = acc_sat;
      end
   end

   gcv_ram #(
      .WIDTH (SCORE_W),
      .DEPTH (N)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_en   (sr_en),
      .rd_addr (sr_addr),
      .rd_data (sum_rd)
   );

   gcv_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (N)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ww_en),
      .wr_addr (load_addr),
      .wr_data (in_w),
      .rd_en   (dv_ff[QUOT_W]),
      .rd_addr (da_ff[QUOT_W]),
      .rd_data (w_rd)
   );

   // maximum scan, first in row-major order wins
   logic               sv_ff, sfirst_ff;
   logic [XW-1:0]      sx_ff, bx_ff;
   logic [YW-1:0]      sy_ff, by_ff;
   logic [SCORE_W-1:0] best_ff;

   always_ff @(posedge clock) begin
      sx_ff     <= cx_ff;
      sy_ff     <= cy_ff;
      sfirst_ff <= (addr_ff == '0);
      if (sv_ff && (sfirst_ff || (sum_rd > best_ff))) begin
         best_ff <= sum_rd;
         bx_ff   <= sx_ff;
         by_ff   <= sy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= scan_issue;
      end
   end

   // result register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {best_ff, POS_W'(by_ff), POS_W'(bx_ff)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* sv/gcv_checker.sv */
`include "gradient_center_voting_assert.svh"

module gcv_checker
   import gcv_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [OP_W-1:0]       req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays put
   `GCV_ASSERT_NEXT(rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a gradient transaction occupies the block for its sweep
   `GCV_ASSERT_NEXT(vote_busy, req_tvalid && req_tready && req_tuser == OP_VOTE, !req_tready)

   // a finish transaction occupies the block for its scan
   `GCV_ASSERT_NEXT(scan_busy, req_tvalid && req_tready && req_tuser == OP_FINISH, !req_tready)

   // the clearing pass follows reset
   `GCV_ASSERT_HOLD(clear_after_reset, $past(reset), !req_tready)

endmodule

bind gradient_center_voting gcv_checker u_gcv_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import gcv_pkg::*;

   localparam int MAP_W = 64;
   localparam int MAP_H = 64;
   localparam int CELLS = MAP_W * MAP_H;
   // one gradient sweep plus pipeline, with margin
   localparam int SWEEP_WAIT = CELLS + 200;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_STALL = 9000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint unsigned SCORE_TOP = 64'h0000_000F_FFFF_FFFF;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [POS_W-1:0]    px;
      logic [POS_W-1:0]    py;
      logic [GRAD_W-1:0]   gx;
      logic [GRAD_W-1:0]   gy;
      logic [WEIGHT_W-1:0] wt;
      bit                  typed;
      logic [POS_W-1:0]    ex;
      logic [POS_W-1:0]    ey;
      logic [SCORE_W-1:0]  escore;
   } stim_row;

   typedef struct {
      logic [POS_W-1:0]   cx;
      logic [POS_W-1:0]   cy;
      logic [SCORE_W-1:0] score;
   } peak_rec;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [SHIFT_W-1:0]    csr_data;

   // predictor state
   logic [SCORE_W-1:0]  score_map [CELLS];
   logic [WEIGHT_W-1:0] weight_img [CELLS];
   bit                  use_weight;
   logic [SHIFT_W-1:0]  vote_shift;

   peak_rec peak_queue[$];
   int      fail_count;
   int      snd_idle_pct;
   int      rcv_idle_pct;
   logic    want_stall;
   bit      stall_done;
   int      stall_left;
   int      quiet_cycles;

   gradient_center_voting #(.IMG_WIDTH(MAP_W), .IMG_HEIGHT(MAP_H)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accumulate one gradient over the whole map
   task automatic cast_gradient(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                                input logic [GRAD_W-1:0] gxr, input logic [GRAD_W-1:0] gyr);
      longint dx, dy, num, gxs, gys;
      longint unsigned un, d2, vote, room;
      int idx;
      gxs = longint'($signed(gxr));
      gys = longint'($signed(gyr));
      for (int cy = 0; cy < MAP_H; cy++) begin
         for (int cx = 0; cx < MAP_W; cx++) begin
            dx = longint'(ox) - cx;
            dy = longint'(oy) - cy;
            idx = cy * MAP_W + cx;
            if (dx == 0 && dy == 0) continue;
            num = dx * gxs + dy * gys;
            if (num <= 0) continue;
            un = num;
            d2 = dx * dx + dy * dy;
            vote = (un * un) / (d2 << 15);
            if (use_weight) vote = (vote * weight_img[idx]) >> vote_shift;
            room = SCORE_TOP - score_map[idx];
            if (vote > room) score_map[idx] = SCORE_TOP;
            else score_map[idx] = score_map[idx] + vote;
         end
      end
   endtask

   // first row-major maximum of the map
   function automatic peak_rec find_peak();
      peak_rec r;
      r.cx = '0;
      r.cy = '0;
      r.score = score_map[0];
      for (int i = 1; i < CELLS; i++) begin
         if (score_map[i] > r.score) begin
            r.score = score_map[i];
            r.cx = POS_W'(i % MAP_W);
            r.cy = POS_W'(i / MAP_W);
         end
      end
      return r;
   endfunction

   // update the predictor for one accepted item
   task automatic predict_item(input stim_row s);
      peak_rec r;
      case (s.op)
         OP_LOAD: begin
            weight_img[s.py * MAP_W + s.px] = s.wt;
            score_map[s.py * MAP_W + s.px] = '0;
         end
         OP_VOTE: cast_gradient(s.px, s.py, s.gx, s.gy);
         OP_FINISH: begin
            r = find_peak();
            if (s.typed) begin
               r.cx = s.ex;
               r.cy = s.ey;
               r.score = s.escore;
            end
            peak_queue.push_back(r);
         end
         default: ;
      endcase
   endtask

   // offer one item, hold valid across back-to-back transactions
   task automatic send_item(input stim_row s);
      req_tvalid <= 1'b1;
      req_tuser  <= s.op;
      req_tdata  <= {4'b0, s.wt, s.gy, s.gx, s.py, s.px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(s);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // wait out results and the silent vote pipeline
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (peak_queue.size() != 0) @(posedge clock);
      repeat (SWEEP_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [SHIFT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_WEIGHT_EN) use_weight = val[0];
      else vote_shift = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [GRAD_W-1:0] pick_grad();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return GRAD_W'($urandom);
      endcase
   endfunction

   function automatic stim_row random_item();
      stim_row s;
      int pick;
      pick = $urandom_range(99);
      s.op = (pick < 30) ? OP_LOAD : (pick < 82) ? OP_VOTE : (pick < 97) ? OP_FINISH : OP_UNUSED;
      s.px = POS_W'($urandom);
      s.py = POS_W'($urandom);
      s.gx = pick_grad();
      s.gy = pick_grad();
      s.wt = WEIGHT_W'($urandom);
      s.typed = 1'b0;
      return s;
   endfunction

   // result checking
   always @(posedge clock) begin
      peak_rec e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (peak_queue.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            fail_count++;
         end else begin
            e = peak_queue.pop_front();
            if (rsp_tdata[5:0] !== e.cx) begin
               $error("center_x expected %0d actual %0d", e.cx, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tdata[11:6] !== e.cy) begin
               $error("center_y expected %0d actual %0d", e.cy, rsp_tdata[11:6]);
               fail_count++;
            end
            if (rsp_tdata[47:12] !== e.score) begin
               $error("peak_score expected %0d actual %0d", e.score, rsp_tdata[47:12]);
               fail_count++;
            end
         end
      end
   end

   // receiver readiness, with one long hold-off on request
   always @(posedge clock) begin
      if (want_stall && !stall_done) begin
         stall_done <= 1'b1;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("gradient_center_voting verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row directed[$];
      stim_row s;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WEIGHT_EN;
      csr_data = '0;
      want_stall = 1'b0;
      stall_done = 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
      fail_count = 0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      use_weight = 1'b1;
      vote_shift = '0;
      for (int i = 0; i < CELLS; i++) begin
         score_map[i] = '0;
         weight_img[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part runs unweighted, so no unloaded weight is used
      write_csr(CSR_WEIGHT_EN, 4'd0);
      directed = '{
         '{OP_FINISH, 0, 0, 0, 0, 0, 1, 0, 0, 0},
         '{OP_UNUSED, 63, 63, 16'hFFFF, 16'hFFFF, 255, 0, 0, 0, 0},
         '{OP_VOTE, 0, 0, 16'h7FFF, 16'h0000, 0, 0, 0, 0, 0},
         '{OP_FINISH, 0, 0, 0, 0, 0, 1, 0, 0, 0},
         '{OP_VOTE, 32, 32, 16'h0000, 16'h0000, 0, 0, 0, 0, 0},
         '{OP_VOTE, 63, 63, 16'h8000, 16'h8000, 0, 0, 0, 0, 0},
         '{OP_VOTE, 0, 63, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0},
         '{OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{OP_LOAD, 10, 10, 0, 0, 255, 0, 0, 0, 0},
         '{OP_LOAD, 63, 0, 0, 0, 0, 0, 0, 0, 0},
         '{OP_LOAD, 0, 63, 0, 0, 128, 0, 0, 0, 0},
         '{OP_VOTE, 5, 7, 16'hCFC7, 16'h5A82, 0, 0, 0, 0, 0},
         '{OP_VOTE, 40, 20, 16'h5A82, 16'h5A82, 0, 0, 0, 0, 0},
         '{OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0}
      };
      foreach (directed[i]) send_item(directed[i]);

      // fill the whole weight map, extremes included
      settle();
      for (int i = 0; i < CELLS; i++) begin
         s = '{OP_LOAD, POS_W'(i % MAP_W), POS_W'(i / MAP_W), 16'hFFFF, 16'h0000,
               (i % 97 == 0) ? 8'd0 : (i % 89 == 0) ? 8'd255 : WEIGHT_W'($urandom),
               0, 0, 0, 0};
         send_item(s);
      end

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         case (phase)
            0: begin
               write_csr(CSR_WEIGHT_EN, 4'd1);
               write_csr(CSR_WEIGHT_SHIFT, 4'd0);
               snd_idle_pct = 29;
               rcv_idle_pct = 72;
            end
            1: begin
               write_csr(CSR_WEIGHT_SHIFT, 4'd8);
               snd_idle_pct = 72;
               rcv_idle_pct = 29;
            end
            default: begin
               write_csr(CSR_WEIGHT_SHIFT, SHIFT_W'($urandom_range(7, 1)));
               write_csr(CSR_WEIGHT_EN, 4'd0);
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
               // hold the result side while finish items keep coming
               want_stall <= 1'b1;
               s = random_item();
               s.op = OP_FINISH;
               send_item(s);
               repeat (3) begin
                  s = random_item();
                  s.op = OP_FINISH;
                  send_item(s);
               end
            end
         endcase
         for (int n = 0; n < 46; n++) send_item(random_item());
         s = random_item();
         s.op = OP_FINISH;
         send_item(s);
      end

      settle();
      if (fail_count == 0) begin
         $display("gradient_center_voting verification clean");
      end else begin
         $display("gradient_center_voting verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/gcv_pkg.sv
sv/gcv_ram.sv
sv/gradient_center_voting.sv
sv/gcv_checker.sv
sim/tb.sv
